// ----- rtl/spta_pkg.sv -----
// Shared constants, codes and types of the sparse polynomial term tables.
// No dependencies; every other file imports this package.
package spta_pkg;

   localparam int TERMS  = 8;
   localparam int IDX_W  = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam int CNT_W  = $clog2(TERMS + 1);
   localparam int COEF_W = 16;
   localparam int EXPO_W = 16;
   localparam int SUM_W  = COEF_W + 1;
   localparam int KIND_W = 2;
   localparam int STS_W  = 3;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INS_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INS_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   // response status codes
   localparam logic [STS_W-1:0] ST_SUM_TERM  = 3'd0;
   localparam logic [STS_W-1:0] ST_SUM_EMPTY = 3'd1;
   localparam logic [STS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STS_W-1:0] ST_REPLACED  = 3'd3;
   localparam logic [STS_W-1:0] ST_ZERO      = 3'd4;
   localparam logic [STS_W-1:0] ST_DROP_LOW  = 3'd5;
   localparam logic [STS_W-1:0] ST_DROP_NEW  = 3'd6;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic [EXPO_W-1:0]        expo;
   } term_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;       // capture the request term
      logic clear;       // empty both tables
      logic sel_b;       // insert targets table B
      logic ins_find;    // compare the term against the selected table
      logic ins_commit;  // update the table and send the insert status
      logic add_init;    // rewind both walk pointers
      logic add_step;    // merge one position of the walk
      logic add_finish;  // send the held sum term or the empty marker
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic    out_free;   // response register can load this cycle
      logic    walk_done;  // both walk pointers have passed their counts
      logic    step_push;  // the next step would send a held term
      cnt_type cnt_a;
      cnt_type cnt_b;
   } dp_sts_type;

endpackage

// ----- rtl/spta_req_if.sv -----
// Request channel: valid/ready handshake carrying one command and its term.
// Depends on spta_pkg.
interface spta_req_if import spta_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [COEF_W-1:0] term_coef;
   logic [EXPO_W-1:0]        term_expo;

   modport source (output valid, kind, term_coef, term_expo, input ready);
   modport sink   (input valid, kind, term_coef, term_expo, output ready);
endinterface

// ----- rtl/spta_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one status or sum term.
// Depends on spta_pkg.
interface spta_rsp_if import spta_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STS_W-1:0]        status;
   logic signed [SUM_W-1:0] sum_coef;
   logic [EXPO_W-1:0]       sum_expo;
   logic                    last_of_run;

   modport source (output valid, status, sum_coef, sum_expo, last_of_run, input ready);
   modport sink   (input valid, status, sum_coef, sum_expo, last_of_run, output ready);
endinterface

// ----- rtl/spta_datapath.sv -----
// Term tables, insert compare/shift logic, merge walk and response register.
// Depends on spta_pkg and spta_rsp_if.
module spta_datapath import spta_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_cmd_type              cmd,
   input  logic signed [COEF_W-1:0] req_term_coef,
   input  logic [EXPO_W-1:0]        req_term_expo,
   output dp_sts_type               sts,
   spta_rsp_if.source               rsp_chan
);

   term_type                tab_a_ff [TERMS];
   term_type                tab_a_in [TERMS];
   term_type                tab_b_ff [TERMS];
   term_type                tab_b_in [TERMS];
   cnt_type                 cnt_a_ff, cnt_a_in;
   cnt_type                 cnt_b_ff, cnt_b_in;
   term_type                term_ff, term_in;
   logic [TERMS-1:0]        gt_ff, gt_in;
   logic [TERMS-1:0]        eq_ff, eq_in;
   cnt_type                 ia_ff, ia_in;
   cnt_type                 ib_ff, ib_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic signed [SUM_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXPO_W-1:0]       pend_expo_ff, pend_expo_in;
   logic                    out_valid_ff, out_valid_in;
   logic [STS_W-1:0]        out_status_ff, out_status_in;
   logic signed [SUM_W-1:0] out_coef_ff, out_coef_in;
   logic [EXPO_W-1:0]       out_expo_ff, out_expo_in;
   logic                    out_last_ff, out_last_in;

   term_type                sel_tab [TERMS];
   term_type                shifted [TERMS];
   cnt_type                 sel_cnt;
   logic [TERMS:0]          prev_gt;
   logic [STS_W-1:0]        ins_status;
   term_type                ent_a, ent_b;
   logic                    a_ok, b_ok, take_a, take_b;
   logic signed [SUM_W-1:0] cand_coef;
   logic [EXPO_W-1:0]       cand_expo;
   logic                    cand_nz;
   logic                    out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   // insert: pick the target table and build its shifted image
   always_comb begin
      for (int i = 0; i < TERMS; i++) begin
         sel_tab[i] = cmd.sel_b ? tab_b_ff[i] : tab_a_ff[i];
      end
      sel_cnt = cmd.sel_b ? cnt_b_ff : cnt_a_ff;
      for (int i = 0; i < TERMS; i++) begin
         gt_in[i] = (CNT_W'(i) < sel_cnt) && (sel_tab[i].expo > term_ff.expo);
         eq_in[i] = (CNT_W'(i) < sel_cnt) && (sel_tab[i].expo == term_ff.expo);
      end
      prev_gt = {gt_ff, 1'b1};
      for (int i = 0; i < TERMS; i++) begin
         shifted[i] = (gt_ff[i] || !prev_gt[i]) ? sel_tab[i] : term_ff;
      end
      for (int i = 1; i < TERMS; i++) begin
         if (!gt_ff[i] && !prev_gt[i]) begin
            shifted[i] = sel_tab[i-1];
         end
      end
      if (term_ff.coef == '0) begin
         ins_status = ST_ZERO;
      end else if (|eq_ff) begin
         ins_status = ST_REPLACED;
      end else if (sel_cnt < CNT_W'(TERMS)) begin
         ins_status = ST_INSERTED;
      end else if (gt_ff[TERMS-1]) begin
         ins_status = ST_DROP_NEW;
      end else begin
         ins_status = ST_DROP_LOW;
      end
   end

   // merge walk: one candidate term per step
   always_comb begin
      ent_a  = tab_a_ff[ia_ff[IDX_W-1:0]];
      ent_b  = tab_b_ff[ib_ff[IDX_W-1:0]];
      a_ok   = ia_ff < cnt_a_ff;
      b_ok   = ib_ff < cnt_b_ff;
      take_a = a_ok && (!b_ok || ent_a.expo > ent_b.expo);
      take_b = b_ok && (!a_ok || ent_b.expo > ent_a.expo);
      if (take_a) begin
         cand_coef = SUM_W'(ent_a.coef);
         cand_expo = ent_a.expo;
      end else if (take_b) begin
         cand_coef = SUM_W'(ent_b.coef);
         cand_expo = ent_b.expo;
      end else begin
         cand_coef = SUM_W'(ent_a.coef) + SUM_W'(ent_b.coef);
         cand_expo = ent_a.expo;
      end
      cand_nz = cand_coef != '0;
   end

   always_comb begin
      tab_a_in      = tab_a_ff;
      tab_b_in      = tab_b_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      term_in       = term_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_expo_in  = pend_expo_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_coef_in   = out_coef_ff;
      out_expo_in   = out_expo_ff;
      out_last_in   = out_last_ff;

      if (cmd.latch) begin
         term_in.coef = req_term_coef;
         term_in.expo = req_term_expo;
      end
      if (cmd.clear) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
      end
      if (cmd.ins_commit) begin
         out_valid_in  = 1'b1;
         out_status_in = ins_status;
         out_coef_in   = '0;
         out_expo_in   = '0;
         out_last_in   = 1'b1;
         if (ins_status == ST_REPLACED) begin
            for (int i = 0; i < TERMS; i++) begin
               if (eq_ff[i]) begin
                  if (cmd.sel_b) tab_b_in[i].coef = term_ff.coef;
                  else           tab_a_in[i].coef = term_ff.coef;
               end
            end
         end else if (ins_status == ST_INSERTED || ins_status == ST_DROP_LOW) begin
            if (cmd.sel_b) tab_b_in = shifted;
            else           tab_a_in = shifted;
            if (ins_status == ST_INSERTED) begin
               if (cmd.sel_b) cnt_b_in = cnt_b_ff + 1'b1;
               else           cnt_a_in = cnt_a_ff + 1'b1;
            end
         end
      end
      if (cmd.add_init) begin
         ia_in         = '0;
         ib_in         = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.add_step) begin
         if (!take_b) ia_in = ia_ff + 1'b1;
         if (!take_a) ib_in = ib_ff + 1'b1;
         if (cand_nz) begin
            // hold the new term; the held one goes out, known not to be last
            pend_valid_in = 1'b1;
            pend_coef_in  = cand_coef;
            pend_expo_in  = cand_expo;
            if (pend_valid_ff) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_SUM_TERM;
               out_coef_in   = pend_coef_ff;
               out_expo_in   = pend_expo_ff;
               out_last_in   = 1'b0;
            end
         end
      end
      if (cmd.add_finish) begin
         out_valid_in  = 1'b1;
         out_last_in   = 1'b1;
         if (pend_valid_ff) begin
            out_status_in = ST_SUM_TERM;
            out_coef_in   = pend_coef_ff;
            out_expo_in   = pend_expo_ff;
         end else begin
            out_status_in = ST_SUM_EMPTY;
            out_coef_in   = '0;
            out_expo_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_a_ff      <= tab_a_in;
      tab_b_ff      <= tab_b_in;
      term_ff       <= term_in;
      // hold the compare vectors from the find cycle until the commit
      if (cmd.ins_find) begin
         gt_ff <= gt_in;
         eq_ff <= eq_in;
      end
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      pend_coef_ff  <= pend_coef_in;
      pend_expo_ff  <= pend_expo_in;
      out_status_ff <= out_status_in;
      out_coef_ff   <= out_coef_in;
      out_expo_ff   <= out_expo_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.sum_coef    = out_coef_ff;
   assign rsp_chan.sum_expo    = out_expo_ff;
   assign rsp_chan.last_of_run = out_last_ff;

   assign sts.out_free  = out_free;
   assign sts.walk_done = !(a_ok || b_ok);
   assign sts.step_push = pend_valid_ff && cand_nz;
   assign sts.cnt_a     = cnt_a_ff;
   assign sts.cnt_b     = cnt_b_ff;

endmodule

// ----- rtl/spta_controller.sv -----
// Sequencer for insert, merge-add and clear commands.
// Depends on spta_pkg and spta_req_if; drives commands into spta_datapath.
module spta_controller import spta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spta_req_if.sink    req_chan,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_INS_FIND  = 5'b00010,
      S_INS_APPLY = 5'b00100,
      S_ADD_WALK  = 5'b01000,
      S_ADD_END   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;

   assign req_chan.ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.sel_b = kind_ff == KIND_INS_B;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd.latch = 1'b1;
               kind_in   = req_chan.kind;
               unique case (req_chan.kind) inside
                  KIND_INS_A, KIND_INS_B: state_in = S_INS_FIND;
                  KIND_ADD: begin
                     cmd.add_init = 1'b1;
                     state_in     = S_ADD_WALK;
                  end
                  default: cmd.clear = 1'b1;
               endcase
            end
         end
         S_INS_FIND: begin
            cmd.ins_find = 1'b1;
            state_in     = S_INS_APPLY;
         end
         S_INS_APPLY: begin
            if (sts.out_free) begin
               cmd.ins_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_ADD_WALK: begin
            if (sts.walk_done) begin
               state_in = S_ADD_END;
            end else if (!sts.step_push || sts.out_free) begin
               cmd.add_step = 1'b1;
            end
         end
         S_ADD_END: begin
            if (sts.out_free) begin
               cmd.add_finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

endmodule

// ----- rtl/sparse_polynomial_table_add.sv -----
// Top level of the sparse polynomial term tables with merge-add.
// Depends on spta_pkg, spta_req_if, spta_rsp_if, spta_controller, spta_datapath.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    kind, term_coef, term_expo
//   rsp_chan   out   valid/ready    status, sum_coef, sum_expo, last_of_run
//
// Insert runs the transfer, a compare against the whole table at once,
// then shift/replace and load the status into the response register.
// Add runs the transfer, then terms of A + terms of B - matched pairs merge
// steps, one per cycle unless stalled, each reading one entry of each table,
// then sees the walk end and sends the final term. Clear is done in the
// transfer. Reset is synchronous and empties both tables. A stalled
// response only holds the walk when a term must leave.
module sparse_polynomial_table_add import spta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spta_req_if.sink    req_chan,
   spta_rsp_if.source  rsp_chan
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequence each command; accept a new transfer only between commands
   spta_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .sts      (sts),
      .cmd      (cmd)
   );

   // hold the tables, run compare/shift and the merge walk, drive responses
   spta_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_term_coef (req_chan.term_coef),
      .req_term_expo (req_chan.term_expo),
      .sts           (sts),
      .rsp_chan      (rsp_chan)
   );

   // a table never grows beyond its capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (sts.cnt_a <= CNT_W'(TERMS)) && (sts.cnt_b <= CNT_W'(TERMS)))
      else $error("term count exceeds table capacity");

   // a response is only loaded when the register can take it
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.ins_commit || cmd.add_finish) |-> sts.out_free)
      else $error("response loaded while previous one is stalled");

   // the walk never steps past the end of both tables
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.add_step |-> !sts.walk_done)
      else $error("merge step after walk finished");

   // a finished add always leaves a response with the last flag set
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.add_finish |=> (rsp_chan.valid && rsp_chan.last_of_run))
      else $error("add finished without a final response");

endmodule
